>>> rtl/core/qrt_pkg.sv
// Shared constants, types and codes of the quantile regression trainer.
package qrt_pkg;

    localparam int MAX_SAMPLES  = 1024;
    localparam int SAMPLE_AW    = $clog2(MAX_SAMPLES);
    localparam int CNT_W        = SAMPLE_AW + 1;
    localparam int MAX_FEATURES = 8;
    localparam int LANE_W       = $clog2(MAX_FEATURES);
    localparam int NCELLS       = MAX_FEATURES + 1;
    localparam int NF_W         = 4;
    localparam int VW           = 32;
    localparam int GW           = 48;
    localparam int PSUM_W       = GW + 4;
    localparam int FACT_W       = 17;
    localparam int DIV_W        = 17;
    localparam int CHG_W        = 37;
    localparam int CHAIN_WAIT   = NCELLS;
    localparam int ONE_Q16      = 65536;
    localparam int STEP_DIV     = 100;

    localparam logic [1:0] CFG_QUANTILE = 2'd0;
    localparam logic [1:0] CFG_ITER_LIM = 2'd1;
    localparam logic [1:0] CFG_TOL      = 2'd2;
    localparam logic [1:0] CFG_NFEAT    = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_MISMATCH = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    localparam logic MODE_FEATURE = 1'b0;
    localparam logic MODE_TARGET  = 1'b1;

    typedef enum logic [3:0] {
        S_LOAD, S_RD, S_MULP, S_CHAIN, S_MULG, S_ACC, S_DIV, S_UPD, S_OUT
    } state_t;

    typedef struct packed {
        logic clear_p;
        logic clear_g;
        logic mul_pred;
        logic mul_grad;
        logic acc;
        logic shift;
    } cell_ctl_t;

endpackage

>>> rtl/core/qrt_cell.sv
// One parameter cell: holds a parameter and its gradient sum, passes the prediction sum on.
module qrt_cell (
    input  logic                            clk,
    input  qrt_pkg::cell_ctl_t              ctl,
    input  logic                            en,
    input  logic signed [qrt_pkg::VW-1:0]     x,
    input  logic signed [qrt_pkg::FACT_W-1:0] factor,
    input  logic signed [qrt_pkg::PSUM_W-1:0] psum_in,
    input  logic signed [qrt_pkg::VW-1:0]     p_in,
    input  logic signed [qrt_pkg::GW-1:0]     g_in,
    output logic signed [qrt_pkg::PSUM_W-1:0] psum_out,
    output logic signed [qrt_pkg::VW-1:0]     p_out,
    output logic signed [qrt_pkg::GW-1:0]     g_out
);
    import qrt_pkg::*;

    logic signed [VW-1:0]     p_reg;
    logic signed [GW-1:0]     g_reg;
    logic signed [2*VW-1:0]   prod_reg;
    logic signed [PSUM_W-1:0] psum_reg;
    logic signed [VW-1:0]     mul_a;
    logic signed [GW-1:0]     term;
    logic signed [GW:0]       gsum;
    logic signed [GW-1:0]     gsat;

    assign mul_a = ctl.mul_grad ? VW'(factor) : p_reg;
    // floor(prod / 2^16); unused feature lanes contribute nothing
    assign term  = en ? prod_reg[2*VW-1:16] : '0;
    assign gsum  = GW'(g_reg) + (GW+1)'(term);

    always_comb
    begin
        if (gsum[GW] != gsum[GW-1])
            gsat = gsum[GW] ? {1'b1, {(GW-1){1'b0}}} : {1'b0, {(GW-1){1'b1}}};
        else
            gsat = gsum[GW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.mul_pred || ctl.mul_grad)
            prod_reg <= mul_a * x;
        psum_reg <= psum_in + PSUM_W'(term);
        if (ctl.clear_p)
            p_reg <= '0;
        else if (ctl.shift)
            p_reg <= p_in;
        // gradient sums travel with their parameters
        if (ctl.clear_g)
            g_reg <= '0;
        else if (ctl.shift)
            g_reg <= g_in;
        else if (ctl.acc)
            g_reg <= gsat;
    end

    assign psum_out = psum_reg;
    assign p_out    = p_reg;
    assign g_out    = g_reg;

endmodule

>>> rtl/core/quantile_regression_trainer_core.sv
// Top level of the quantile regression trainer: sample stores, fit sequencer, cell row.
//
//  channel | dir | handshake              | word
//  s_      | in  | s_tvalid / s_tready    | tdata value, tuser mode, tlast last sample
//  m_      | out | m_tvalid / m_tready    | tdata index/value/iterations, tuser status, tlast
//  cfg_    | in  | cfg_valid / cfg_ready  | cfg_index register, cfg_data value
//
// Load words are taken whenever s_tready is high. A fit runs
//   iters iterations over n samples: each sample needs a store read,
//   a multiply, a ripple of the prediction sum along the cell row, and a
//   gradient multiply/accumulate; each iteration ends with 9 serial divides, each a
//   load step, 48 quotient steps and an update step.
// One word per parameter follows a fit, one status word an error; each held until m_tready.
// rst_n clears control and configuration registers; stores are undefined until written.
// s_tready is low from the closing last target word until the final result word is taken.
module quantile_regression_trainer_core
    import qrt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [31:0] value
    input  logic        s_tuser,    // [0] mode
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,    // [3:0] param_index, [35:4] param_value,
                                    // [51:36] iterations_run, [55:52] zero
    output logic [1:0]  m_tuser,    // [1:0] status
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    // configuration
    logic [15:0]     quantile_reg;
    logic [15:0]     iter_lim_reg;
    logic [30:0]     tol_reg;
    logic [NF_W-1:0] nfeat_reg;
    logic [NF_W-1:0] nf;

    assign cfg_ready = 1'b1;
    assign nf = (nfeat_reg > NF_W'(MAX_FEATURES)) ? NF_W'(MAX_FEATURES) : nfeat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quantile_reg <= 16'd32768;
            iter_lim_reg <= 16'd1000;
            tol_reg      <= 31'd66;
            nfeat_reg    <= NF_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_QUANTILE: quantile_reg <= cfg_data[15:0];
                CFG_ITER_LIM: iter_lim_reg <= cfg_data[15:0];
                CFG_TOL:      tol_reg      <= cfg_data[30:0];
                CFG_NFEAT:    nfeat_reg    <= cfg_data[NF_W-1:0];
                default:      ;
            endcase
        end
    end

    // control registers
    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg;       // stored samples
    logic [NF_W-1:0]     pos_reg;       // feature position in sample
    logic [1:0]          err_reg;       // sticky load error
    logic [1:0]          status_reg;
    logic [CNT_W-1:0]    smp_reg;       // sample being trained on
    logic [3:0]          step_reg;      // chain wait / parameter update count
    logic [5:0]          dstep_reg;
    logic [15:0]         iter_reg;
    logic [NF_W-1:0]     oidx_reg;
    logic [CHG_W-1:0]    chg_reg;

    // payload registers
    logic [DIV_W-1:0]         div_reg;
    logic [DIV_W-1:0]         rem_reg;
    logic [GW-1:0]            dvd_reg;
    logic                     neg_reg;
    logic signed [FACT_W-1:0] fac_reg;

    logic in_acc;
    assign in_acc = s_tvalid && s_tready;

    // load decision for the current word
    logic [1:0]       err_new;
    logic             wr_feat, wr_tgt;
    always_comb
    begin
        err_new = err_reg;
        wr_feat = 1'b0;
        wr_tgt  = 1'b0;
        if (err_reg == ST_OK)
        begin
            if (s_tuser == MODE_FEATURE)
            begin
                if (pos_reg >= nf)
                    err_new = ST_MISMATCH;
                else if (cnt_reg >= CNT_W'(MAX_SAMPLES))
                    err_new = ST_OVERFLOW;
                else
                    wr_feat = 1'b1;
            end
            else
            begin
                if (pos_reg != nf)
                    err_new = ST_MISMATCH;
                else if (cnt_reg >= CNT_W'(MAX_SAMPLES))
                    err_new = ST_OVERFLOW;
                else
                    wr_tgt = 1'b1;
            end
        end
    end

    logic [CNT_W-1:0] cnt_new;
    logic             fit_go, stat_go;
    assign cnt_new = wr_tgt ? cnt_reg + CNT_W'(1) : cnt_reg;
    assign stat_go = in_acc && s_tuser == MODE_TARGET && s_tlast
                     && (err_new != ST_OK || cnt_new == '0);
    assign fit_go  = in_acc && s_tuser == MODE_TARGET && s_tlast && !stat_go;

    // sample stores: one lane memory per feature position, plus targets
    logic [VW-1:0] feat_mem [MAX_FEATURES][MAX_SAMPLES];
    logic [VW-1:0] tgt_mem  [MAX_SAMPLES];
    logic [VW-1:0] feat_rd_reg [MAX_FEATURES];
    logic [VW-1:0] tgt_rd_reg;
    logic          rd_en;

    always_ff @(posedge clk)
    begin
        if (in_acc && wr_feat)
            feat_mem[pos_reg[LANE_W-1:0]][cnt_reg[SAMPLE_AW-1:0]] <= s_tdata;
        if (in_acc && wr_tgt)
            tgt_mem[cnt_reg[SAMPLE_AW-1:0]] <= s_tdata;
        if (rd_en)
        begin
            for (int l = 0; l < MAX_FEATURES; l++)
                feat_rd_reg[l] <= feat_mem[l][smp_reg[SAMPLE_AW-1:0]];
            tgt_rd_reg <= tgt_mem[smp_reg[SAMPLE_AW-1:0]];
        end
    end

    // cell row
    cell_ctl_t                ctl;
    logic signed [PSUM_W-1:0] psum [NCELLS];
    logic signed [VW-1:0]     pval [NCELLS];
    logic signed [GW-1:0]     gval [NCELLS];
    logic signed [VW-1:0]     nv;

    for (genvar k = 0; k < NCELLS; k++)
    begin : g_cell
        logic signed [VW-1:0]     cx;
        logic signed [PSUM_W-1:0] cin;
        logic signed [VW-1:0]     pin;
        logic signed [GW-1:0]     gin;
        if (k == 0)
        begin : g_head
            assign cx  = VW'(ONE_Q16);     // intercept sees feature 1.0
            assign cin = '0;
            assign pin = nv;
            assign gin = '0;
        end
        else
        begin : g_body
            assign cx  = feat_rd_reg[k-1];
            assign cin = psum[k-1];
            assign pin = pval[k-1];
            assign gin = gval[k-1];
        end
        qrt_cell u_cell (
            .clk      (clk),
            .ctl      (ctl),
            .en       (NF_W'(k) <= nf),
            .x        (cx),
            .factor   (fac_reg),
            .psum_in  (cin),
            .p_in     (pin),
            .g_in     (gin),
            .psum_out (psum[k]),
            .p_out    (pval[k]),
            .g_out    (gval[k])
        );
    end

    // update of the parameter leaving the end of the row
    logic signed [GW:0]   qs;
    logic signed [GW+1:0] usum;
    logic signed [VW:0]   dlt;
    logic [VW:0]          adlt;
    logic [CHG_W-1:0]     chg_new;
    logic                 last_upd, stop;
    logic [15:0]          iter_new;

    always_comb
    begin
        qs   = neg_reg ? -(GW+1)'(dvd_reg) : (GW+1)'(dvd_reg);
        usum = (GW+2)'(pval[NCELLS-1]) + (GW+2)'(qs);
        if (usum > (GW+2)'(signed'({1'b0, {(VW-1){1'b1}}})))
            nv = {1'b0, {(VW-1){1'b1}}};
        else if (usum < (GW+2)'(signed'({1'b1, {(VW-1){1'b0}}})))
            nv = {1'b1, {(VW-1){1'b0}}};
        else
            nv = usum[VW-1:0];
        dlt  = (VW+1)'(nv) - (VW+1)'(pval[NCELLS-1]);
        adlt = dlt[VW] ? unsigned'(-dlt) : unsigned'(dlt);
    end
    assign chg_new  = chg_reg + CHG_W'(adlt);
    assign last_upd = step_reg == 4'(NCELLS - 1);
    assign iter_new = iter_reg + 16'd1;
    assign stop     = chg_new < CHG_W'(tol_reg) || iter_new == iter_lim_reg;

    logic pred_lt;
    assign pred_lt = PSUM_W'(signed'(tgt_rd_reg)) < psum[NCELLS-1];

    logic last_smp;
    assign last_smp = smp_reg == cnt_reg - CNT_W'(1);

    logic out_acc;
    assign out_acc = m_tvalid && m_tready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_LOAD:  if (stat_go)
                         state_next = S_OUT;
                     else if (fit_go)
                         state_next = (iter_lim_reg == '0) ? S_OUT : S_RD;
            S_RD:    state_next = S_MULP;
            S_MULP:  state_next = S_CHAIN;
            S_CHAIN: if (step_reg == 4'(CHAIN_WAIT)) state_next = S_MULG;
            S_MULG:  state_next = S_ACC;
            S_ACC:   state_next = last_smp ? S_DIV : S_RD;
            S_DIV:   if (dstep_reg == 6'(GW)) state_next = S_UPD;
            S_UPD:   if (!last_upd)
                         state_next = S_DIV;
                     else
                         state_next = stop ? S_OUT : S_RD;
            S_OUT:   if (out_acc && m_tlast) state_next = S_LOAD;
            default: state_next = S_LOAD;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        ctl      = '0;
        rd_en    = 1'b0;
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        case (state_reg)
            S_LOAD:
            begin
                s_tready    = 1'b1;
                ctl.clear_p = fit_go;
                ctl.clear_g = fit_go;
            end
            S_RD:    rd_en        = 1'b1;
            S_MULP:  ctl.mul_pred = 1'b1;
            S_MULG:  ctl.mul_grad = 1'b1;
            S_ACC:   ctl.acc      = 1'b1;
            S_UPD:
            begin
                ctl.shift   = 1'b1;
                ctl.clear_g = last_upd;
            end
            S_OUT:   m_tvalid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_LOAD;
            cnt_reg    <= '0;
            pos_reg    <= '0;
            err_reg    <= ST_OK;
            status_reg <= ST_OK;
            smp_reg    <= '0;
            step_reg   <= '0;
            dstep_reg  <= '0;
            iter_reg   <= '0;
            oidx_reg   <= '0;
            chg_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                S_LOAD:
                    if (in_acc)
                    begin
                        err_reg <= err_new;
                        cnt_reg <= cnt_new;
                        if (s_tuser == MODE_TARGET)
                            pos_reg <= '0;
                        else if (wr_feat)
                            pos_reg <= pos_reg + NF_W'(1);
                        if (stat_go)
                            status_reg <= (err_new != ST_OK) ? err_new : ST_EMPTY;
                        else
                            status_reg <= ST_OK;
                        smp_reg  <= '0;
                        iter_reg <= '0;
                        oidx_reg <= '0;
                        chg_reg  <= '0;
                    end
                S_RD:    step_reg <= '0;
                S_CHAIN: step_reg <= step_reg + 4'd1;
                S_ACC:
                begin
                    smp_reg   <= last_smp ? '0 : smp_reg + CNT_W'(1);
                    step_reg  <= '0;
                    dstep_reg <= '0;
                end
                S_DIV:   dstep_reg <= dstep_reg + 6'd1;
                S_UPD:
                begin
                    dstep_reg <= '0;
                    if (last_upd)
                    begin
                        step_reg <= '0;
                        chg_reg  <= '0;
                        iter_reg <= iter_new;
                    end
                    else
                    begin
                        step_reg <= step_reg + 4'd1;
                        chg_reg  <= chg_new;
                    end
                end
                S_OUT:
                    if (out_acc)
                    begin
                        oidx_reg <= oidx_reg + NF_W'(1);
                        if (m_tlast)
                        begin
                            cnt_reg <= '0;
                            pos_reg <= '0;
                            err_reg <= ST_OK;
                        end
                    end
                default: ;
            endcase
        end
    end

    // divide datapath: |gradient| / (100 * n), one quotient bit a cycle
    logic [DIV_W:0] rem_w;
    logic           ge;
    assign rem_w = {rem_reg, dvd_reg[GW-1]};
    assign ge    = rem_w >= {1'b0, div_reg};

    always_ff @(posedge clk)
    begin
        if (fit_go)
            div_reg <= DIV_W'(cnt_new) * DIV_W'(STEP_DIV);
        if (state_reg == S_CHAIN && step_reg == 4'(CHAIN_WAIT))
            fac_reg <= pred_lt ? signed'({1'b0, quantile_reg} - FACT_W'(ONE_Q16))
                               : signed'({1'b0, quantile_reg});
        if (state_reg == S_DIV)
        begin
            if (dstep_reg == '0)
            begin
                // the parameter to update and its gradient sit at the end of the row
                neg_reg <= gval[NCELLS-1][GW-1];
                dvd_reg <= gval[NCELLS-1][GW-1] ? unsigned'(-gval[NCELLS-1])
                                                : unsigned'(gval[NCELLS-1]);
                rem_reg <= '0;
            end
            else
            begin
                rem_reg <= ge ? DIV_W'(rem_w - {1'b0, div_reg}) : rem_w[DIV_W-1:0];
                dvd_reg <= {dvd_reg[GW-2:0], ge};
            end
        end
    end

    // result word
    logic signed [VW-1:0] oval;
    always_comb
    begin
        oval = '0;
        for (int k = 0; k < NCELLS; k++)
            if (oidx_reg == NF_W'(k))
                oval = pval[k];
        if (status_reg != ST_OK)
            oval = '0;
    end

    assign m_tdata = {4'b0, (status_reg == ST_OK) ? iter_reg : 16'd0, oval, oidx_reg};
    assign m_tuser = status_reg;
    assign m_tlast = (status_reg != ST_OK) || (oidx_reg == nf);

    // checks
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input taken while results pending");

    a_status_single: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != ST_OK |-> m_tlast && m_tdata[3:0] == 4'd0)
        else $error("status result not single");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[3:0] <= nf)
        else $error("parameter index beyond feature count");

    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_UPD |-> $past(dstep_reg) == 6'(GW))
        else $error("update without full divide");

endmodule

>>> verif/testbench.sv
// Self-checking testbench for the quantile regression trainer core.
`timescale 1ns / 1ps

module testbench;
    import qrt_pkg::*;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int SETTLE_CYCLES  = 40;

    typedef struct {
        logic        mode;
        logic [31:0] value;
        logic        last;
        bit          typed;      // expectation written into the row
        logic [1:0]  status;     // typed status for error rows
    } stim_row_t;

    typedef struct {
        logic [3:0]  idx;
        logic [31:0] val;
        logic [15:0] iters;
        logic [1:0]  status;
        logic        fin;
    } param_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    quantile_regression_trainer_core i_dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mirror of the block: registers and sample stores
    logic [15:0] q_reg;
    logic [15:0] iter_lim_reg;
    logic [30:0] tol_reg;
    logic [3:0]  nfeat_reg;
    longint      feat_mem [MAX_SAMPLES * MAX_FEATURES];
    longint      targ_mem [MAX_SAMPLES];
    longint      params [NCELLS];
    int          smp_count;
    int          feat_pos;
    logic [1:0]  load_err;

    param_word_t pending_params[$];
    int          fails = 0;
    bit          no_idle = 0;
    bit          rx_long_hold = 0;

    function automatic longint sat(longint v, int bits);
        longint hi;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        if (v > hi)
            return hi;
        if (v < -hi - 1)
            return -hi - 1;
        return v;
    endfunction

    function automatic int lanes_used();
        return (nfeat_reg > MAX_FEATURES) ? MAX_FEATURES : int'(nfeat_reg);
    endfunction

    // Subgradient fit over the stored set; returns iterations run
    function automatic int fit_params(int nf);
        longint grad [NCELLS];
        longint pos_f, neg_f, divisor, pred, f, nv, d, change;
        int it, i, j;
        pos_f = longint'(q_reg);
        neg_f = longint'(q_reg) - ONE_Q16;
        divisor = longint'(smp_count) * STEP_DIV;
        for (j = 0; j < NCELLS; j++)
            params[j] = 0;
        for (it = 0; it < iter_lim_reg; it++)
        begin
            change = 0;
            for (j = 0; j < NCELLS; j++)
                grad[j] = 0;
            for (i = 0; i < smp_count; i++)
            begin
                pred = params[0];
                for (j = 0; j < nf; j++)
                    pred += (params[j + 1] * feat_mem[i * MAX_FEATURES + j]) >>> 16;
                f = (targ_mem[i] < pred) ? neg_f : pos_f;
                grad[0] = sat(grad[0] + f, GW);
                for (j = 0; j < nf; j++)
                    grad[j + 1] = sat(grad[j + 1]
                                      + ((f * feat_mem[i * MAX_FEATURES + j]) >>> 16), GW);
            end
            for (j = 0; j <= nf; j++)
            begin
                nv = sat(params[j] + grad[j] / divisor, VW);
                d = nv - params[j];
                params[j] = nv;
                change += (d < 0) ? -d : d;
            end
            if (change < longint'(tol_reg))
                return it + 1;
        end
        return iter_lim_reg;
    endfunction

    function automatic void push_status(logic [1:0] st);
        param_word_t w;
        w = '{idx: '0, val: '0, iters: '0, status: st, fin: 1'b1};
        pending_params.push_back(w);
    endfunction

    // Advance the mirror by one accepted input word
    function automatic void predict_word(logic mode, logic [31:0] value, logic last,
                                         bit typed, logic [1:0] typed_st);
        int nf, iters, j;
        param_word_t w;
        nf = lanes_used();
        if (mode == MODE_FEATURE)
        begin
            if (load_err == ST_OK)
            begin
                if (feat_pos >= nf)
                    load_err = ST_MISMATCH;
                else if (smp_count >= MAX_SAMPLES)
                    load_err = ST_OVERFLOW;
                else
                begin
                    feat_mem[smp_count * MAX_FEATURES + feat_pos] = longint'(signed'(value));
                    feat_pos++;
                end
            end
            return;
        end
        if (load_err == ST_OK)
        begin
            if (feat_pos != nf)
                load_err = ST_MISMATCH;
            else if (smp_count >= MAX_SAMPLES)
                load_err = ST_OVERFLOW;
            else
            begin
                targ_mem[smp_count] = longint'(signed'(value));
                smp_count++;
            end
        end
        feat_pos = 0;
        if (!last)
            return;
        if (typed)
            push_status(typed_st);
        else if (load_err != ST_OK || smp_count == 0)
            push_status(load_err != ST_OK ? load_err : ST_EMPTY);
        else
        begin
            iters = fit_params(nf);
            for (j = 0; j <= nf; j++)
            begin
                w.idx = j[3:0];
                w.val = params[j][31:0];
                w.iters = iters[15:0];
                w.status = ST_OK;
                w.fin = (j == nf);
                pending_params.push_back(w);
            end
        end
        smp_count = 0;
        load_err = ST_OK;
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_QUANTILE: q_reg = data[15:0];
            CFG_ITER_LIM: iter_lim_reg = data[15:0];
            CFG_TOL:      tol_reg = data[30:0];
            default:      nfeat_reg = data[3:0];
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_regs(int q, int lim, int tol, int nf);
        write_reg(CFG_QUANTILE, q);
        write_reg(CFG_ITER_LIM, lim);
        write_reg(CFG_TOL, tol);
        write_reg(CFG_NFEAT, nf);
    endtask

    // Send one word; called at a falling edge, returns at the falling edge after accept
    task automatic send_word(logic mode, logic [31:0] value, logic last,
                             bit typed = 0, logic [1:0] typed_st = ST_OK);
        int gap;
        gap = no_idle ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12));
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= mode;
        s_tdata <= value;
        s_tlast <= last;
        do
            @(posedge clk);
        while (!s_tready);
        predict_word(mode, value, last, typed, typed_st);
        @(negedge clk);
    endtask

    // Called at the falling edge after the last accepted word
    task automatic drain();
        s_tvalid <= 1'b0;
        wait (pending_params.size() == 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic [31:0] draw_value();
        case ($urandom_range(0, 5))
            0:       return $urandom;
            1:       return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return $urandom_range(0, 524287) - 262144;   // within +-4.0
        endcase
    endfunction

    // A set of samples closed by a last target; sometimes broken on purpose
    task automatic send_set(int nsamp);
        int nf, k, s;
        bit broken;
        nf = lanes_used();
        broken = ($urandom_range(0, 9) == 0);
        for (s = 0; s < nsamp; s++)
        begin
            k = nf;
            if (broken && s == nsamp - 1)
                k = $urandom_range(0, 1) ? nf + 1 : (nf > 0 ? nf - 1 : 1);
            repeat (k) send_word(MODE_FEATURE, draw_value(), $urandom_range(0, 7) == 0);
            send_word(MODE_TARGET, draw_value(), s == nsamp - 1);
        end
    endtask

    stim_row_t directed [] = '{
        // after reset, nf = 1: a lone target is a short sample
        '{MODE_TARGET,  32'h0000_0000, 1'b1, 1, ST_MISMATCH},
        // extremes, nf = 2
        '{MODE_FEATURE, 32'h7fff_ffff, 1'b0, 0, ST_OK},
        '{MODE_FEATURE, 32'h8000_0000, 1'b0, 0, ST_OK},
        '{MODE_TARGET,  32'h0000_0000, 1'b0, 0, ST_OK},
        '{MODE_FEATURE, 32'h0001_0000, 1'b0, 0, ST_OK},
        '{MODE_FEATURE, 32'hffff_0000, 1'b0, 0, ST_OK},
        '{MODE_TARGET,  32'h7fff_ffff, 1'b1, 0, ST_OK},
        // extra feature
        '{MODE_FEATURE, 32'h0000_1000, 1'b0, 0, ST_OK},
        '{MODE_FEATURE, 32'h0000_2000, 1'b0, 0, ST_OK},
        '{MODE_FEATURE, 32'h0000_3000, 1'b0, 0, ST_OK},
        '{MODE_TARGET,  32'h0000_4000, 1'b1, 1, ST_MISMATCH},
        // short sample, then the error sticks through a good sample
        '{MODE_FEATURE, 32'h0002_0000, 1'b0, 0, ST_OK},
        '{MODE_TARGET,  32'h0001_0000, 1'b0, 0, ST_OK},
        '{MODE_FEATURE, 32'h0002_0000, 1'b0, 0, ST_OK},
        '{MODE_FEATURE, 32'h0003_0000, 1'b0, 0, ST_OK},
        '{MODE_TARGET,  32'h8000_0000, 1'b1, 1, ST_MISMATCH},
        // last flag on a feature is ignored
        '{MODE_FEATURE, 32'h0001_8000, 1'b1, 0, ST_OK},
        '{MODE_FEATURE, 32'hfffe_0000, 1'b0, 0, ST_OK},
        '{MODE_TARGET,  32'h0005_0000, 1'b0, 0, ST_OK},
        '{MODE_FEATURE, 32'h0000_0000, 1'b0, 0, ST_OK},
        '{MODE_FEATURE, 32'hffff_ffff, 1'b0, 0, ST_OK},
        '{MODE_TARGET,  32'hfff0_0000, 1'b1, 0, ST_OK}
    };

    // Result side: random stalls, one long hold-off on request
    initial
    begin : result_side
        int stall;
        param_word_t w;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (rx_long_hold)
            begin
                stall = 400;
                rx_long_hold = 0;
            end
            else
                stall = no_idle ? 0 : $urandom_range(0, 12);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            if (pending_params.size() == 0)
            begin
                $error("unexpected result word idx=%0d", m_tdata[3:0]);
                fails++;
            end
            else
            begin
                w = pending_params.pop_front();
                if (m_tdata[3:0] !== w.idx)
                begin
                    $error("param_index exp %0d got %0d", w.idx, m_tdata[3:0]);
                    fails++;
                end
                if (m_tdata[35:4] !== w.val)
                begin
                    $error("param_value exp %h got %h", w.val, m_tdata[35:4]);
                    fails++;
                end
                if (m_tdata[51:36] !== w.iters)
                begin
                    $error("iterations_run exp %0d got %0d", w.iters, m_tdata[51:36]);
                    fails++;
                end
                if (m_tuser !== w.status)
                begin
                    $error("status exp %0d got %0d", w.status, m_tuser);
                    fails++;
                end
                if (m_tlast !== w.fin)
                begin
                    $error("last_result exp %0d got %0d", w.fin, m_tlast);
                    fails++;
                end
            end
        end
    end

    // Watchdog: cycles without any accepted word
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Random phases: quantile, iteration limit, tolerance, feature count
    int phase_cfg [8][4] = '{
        '{1,     3,     0,          1},
        '{65535, 4,     0,          8},
        '{0,     3,     0,          3},
        '{30000, 0,     0,          2},
        '{20000, 65535, 2147483647, 4},
        '{40000, 6,     66,         15},
        '{50000, 2,     1000,       0},
        '{12345, 5,     3,          5}
    };

    initial
    begin : stimulus
        int p, r;
        q_reg = 16'd32768;
        iter_lim_reg = 16'd1000;
        tol_reg = 31'd66;
        nfeat_reg = 4'd1;
        smp_count = 0;
        feat_pos = 0;
        load_err = ST_OK;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed rows; first one runs on the reset settings
        foreach (directed[r])
        begin
            if (r == 1)
            begin
                drain();
                set_regs(32768, 5, 0, 2);
            end
            send_word(directed[r].mode, directed[r].value, directed[r].last,
                      directed[r].typed, directed[r].status);
        end

        // random sets across several settings
        for (p = 0; p < 8; p++)
        begin
            drain();
            set_regs(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2], phase_cfg[p][3]);
            no_idle = (p == 3);
            if (p == 1)
                rx_long_hold = 1;
            for (r = 0; r < 3; r++)
                send_set($urandom_range(1, 3));
        end
        no_idle = 0;

        drain();
        if (fails == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
